// File: rtl/core/kvtok_pkg.sv
// kvtok_pkg: types, character constants and the per-byte lexer functions of the
// key/value text tokenizer. No dependencies; used by kvtok_burst_queue and the top level.
`timescale 1ns / 1ps

package kvtok_pkg;

  localparam int unsigned KVTOK_MAX_DEPTH  = 32;
  localparam int unsigned KVTOK_MAX_EVENTS = 8;
  localparam int unsigned KVTOK_CNT_W      = $clog2(KVTOK_MAX_EVENTS + 1);
  localparam int unsigned KVTOK_IDX_W      = $clog2(KVTOK_MAX_EVENTS);

  // byte-order mark and syntax bytes
  localparam logic [7:0] CH_BOM0   = 8'hEF;
  localparam logic [7:0] CH_BOM1   = 8'hBB;
  localparam logic [7:0] CH_BOM2   = 8'hBF;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam logic [1:0] BOM_DONE = 2'd3;

  typedef enum logic [2:0] {
    KIND_KEY_BYTE,
    KIND_KEY_END,
    KIND_VAL_BYTE,
    KIND_VAL_END,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_NO_VALUE,
    KIND_DONE
  } kvtok_kind_t;

  typedef enum logic [2:0] {
    MODE_GAP,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLK,
    MODE_BLKSTAR,
    MODE_QUOTE,
    MODE_ESC,
    MODE_BARE
  } kvtok_mode_t;

  typedef struct packed {
    logic [1:0]  bom;
    kvtok_mode_t mode;
    logic        expv;
    logic [5:0]  level;
    logic        seen;
    logic        fin;
    logic        ovf;
  } kvtok_state_t;

  localparam kvtok_state_t KVTOK_STATE_RESET = '{
    bom: 2'd0, mode: MODE_GAP, expv: 1'b0, level: 6'd0,
    seen: 1'b0, fin: 1'b0, ovf: 1'b0
  };

  typedef struct packed {
    kvtok_kind_t kind;
    logic [7:0]  data;
    logic [5:0]  depth;
    logic        succ;
    logic        ovf;
  } kvtok_event_t;

  typedef struct packed {
    kvtok_event_t [KVTOK_MAX_EVENTS-1:0] ev;
    logic [KVTOK_CNT_W-1:0]              cnt;
  } kvtok_burst_t;

  typedef struct packed {
    kvtok_state_t st;
    kvtok_burst_t burst;
    logic         again;
  } kvtok_work_t;

  function automatic kvtok_work_t kvtok_put(kvtok_work_t w, kvtok_kind_t kind,
                                            logic [7:0] data, logic succ, logic ovf);
    kvtok_event_t e;
    e.kind  = kind;
    e.data  = data;
    e.depth = w.st.level;
    e.succ  = succ;
    e.ovf   = ovf;
    if (w.burst.cnt < KVTOK_CNT_W'(KVTOK_MAX_EVENTS)) begin
      w.burst.ev[w.burst.cnt[KVTOK_IDX_W-1:0]] = e;
      w.burst.cnt = w.burst.cnt + KVTOK_CNT_W'(1);
    end
    return w;
  endfunction

  function automatic kvtok_work_t kvtok_done(kvtok_work_t w);
    w = kvtok_put(w, KIND_DONE, 8'h00, w.st.seen, w.st.ovf);
    w.st.fin = 1'b1;
    return w;
  endfunction

  function automatic kvtok_work_t kvtok_tok_byte(kvtok_work_t w, logic [7:0] b);
    return kvtok_put(w, w.st.expv ? KIND_VAL_BYTE : KIND_KEY_BYTE, b, 1'b0, 1'b0);
  endfunction

  function automatic kvtok_work_t kvtok_tok_finish(kvtok_work_t w);
    if (w.st.expv) begin
      w = kvtok_put(w, KIND_VAL_END, 8'h00, 1'b0, 1'b0);
      w.st.expv = 1'b0;
    end else begin
      w = kvtok_put(w, KIND_KEY_END, 8'h00, 1'b0, 1'b0);
      if (w.st.level == 6'd0) w.st.seen = 1'b1;
      w.st.expv = 1'b1;
    end
    return w;
  endfunction

  function automatic kvtok_work_t kvtok_open(kvtok_work_t w, logic [5:0] max_depth);
    if (w.st.expv) begin
      w.st.expv = 1'b0;
      if (w.st.level >= max_depth) w.st.ovf = 1'b1;
      else w.st.level = w.st.level + 6'd1;
      w = kvtok_put(w, KIND_OPEN, 8'h00, 1'b0, 1'b0);
    end
    return w;
  endfunction

  function automatic kvtok_work_t kvtok_close(kvtok_work_t w);
    if (w.st.expv) begin
      w = kvtok_put(w, KIND_NO_VALUE, 8'h00, 1'b0, 1'b0);
      w.st.expv = 1'b0;
    end
    if (w.st.level == 6'd0) begin
      w = kvtok_done(w);
    end else begin
      w.st.level = w.st.level - 6'd1;
      w = kvtok_put(w, KIND_CLOSE, 8'h00, 1'b0, 1'b0);
    end
    return w;
  endfunction

  // One pass of the lexer; again is set when the same byte must be looked at once more
  function automatic kvtok_work_t kvtok_lex_once(kvtok_work_t w, logic [7:0] b,
                                                 logic [5:0] max_depth);
    w.again = 1'b0;
    if (!w.st.fin) begin
      case (w.st.mode)
        MODE_GAP: begin
          if (b <= CH_SPACE) begin
          end else if (b == CH_SLASH) begin
            w.st.mode = MODE_SLASH;
          end else if (b == CH_LBRACE) begin
            w = kvtok_open(w, max_depth);
          end else if (b == CH_RBRACE) begin
            w = kvtok_close(w);
          end else if (b == CH_QUOTE) begin
            w.st.mode = MODE_QUOTE;
          end else begin
            w = kvtok_tok_byte(w, b);
            w.st.mode = MODE_BARE;
          end
        end
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            w.st.mode = MODE_LINE;
          end else if (b == CH_STAR) begin
            w.st.mode = MODE_BLK;
          end else begin
            w = kvtok_tok_byte(w, CH_SLASH);
            w.st.mode = MODE_BARE;
            w.again = 1'b1;
          end
        end
        MODE_LINE: begin
          if (b == CH_NL) w.st.mode = MODE_GAP;
        end
        MODE_BLK: begin
          if (b == CH_STAR) w.st.mode = MODE_BLKSTAR;
        end
        MODE_BLKSTAR: begin
          if (b == CH_SLASH) w.st.mode = MODE_GAP;
          else if (b != CH_STAR) w.st.mode = MODE_BLK;
        end
        MODE_QUOTE: begin
          if (b == CH_QUOTE) begin
            w = kvtok_tok_finish(w);
            w.st.mode = MODE_GAP;
          end else if (b == CH_BSLASH) begin
            w.st.mode = MODE_ESC;
          end else begin
            w = kvtok_tok_byte(w, b);
          end
        end
        MODE_ESC: begin
          if (b == CH_LOW_N) w = kvtok_tok_byte(w, CH_NL);
          else if (b == CH_LOW_T) w = kvtok_tok_byte(w, CH_TAB);
          else w = kvtok_tok_byte(w, b);
          w.st.mode = MODE_QUOTE;
        end
        MODE_BARE: begin
          if (b inside {[8'h00:CH_SPACE], CH_LBRACE, CH_RBRACE, CH_QUOTE}) begin
            w = kvtok_tok_finish(w);
            w.st.mode = MODE_GAP;
            w.again = 1'b1;
          end else begin
            w = kvtok_tok_byte(w, b);
          end
        end
        default: begin
          w.st.mode = MODE_GAP;
          w.again = 1'b1;
        end
      endcase
    end
    return w;
  endfunction

  // slash -> bare -> gap is the longest chain: three passes cover every byte
  function automatic kvtok_work_t kvtok_lex(kvtok_work_t w, logic [7:0] b,
                                            logic [5:0] max_depth);
    w = kvtok_lex_once(w, b, max_depth);
    if (w.again) w = kvtok_lex_once(w, b, max_depth);
    if (w.again) w = kvtok_lex_once(w, b, max_depth);
    w.again = 1'b0;
    return w;
  endfunction

  // Held mark bytes can only ever be EF then BB, so they are replayed as constants
  function automatic kvtok_work_t kvtok_replay(kvtok_work_t w, logic [5:0] max_depth);
    logic [1:0] n;
    n = w.st.bom;
    w.st.bom = BOM_DONE;
    if (n >= 2'd1) w = kvtok_lex(w, CH_BOM0, max_depth);
    if (n >= 2'd2) w = kvtok_lex(w, CH_BOM1, max_depth);
    return w;
  endfunction

  function automatic kvtok_work_t kvtok_finish_text(kvtok_work_t w, logic [5:0] max_depth);
    if (w.st.bom != BOM_DONE) w = kvtok_replay(w, max_depth);
    if (!w.st.fin) begin
      case (w.st.mode)
        MODE_SLASH: begin
          w = kvtok_tok_byte(w, CH_SLASH);
          w = kvtok_tok_finish(w);
        end
        MODE_ESC: begin
          w = kvtok_tok_byte(w, CH_BSLASH);
          w = kvtok_tok_finish(w);
        end
        MODE_QUOTE, MODE_BARE: w = kvtok_tok_finish(w);
        default: begin
        end
      endcase
      w.st.mode = MODE_GAP;
      if (w.st.expv) begin
        w = kvtok_put(w, KIND_NO_VALUE, 8'h00, 1'b0, 1'b0);
        w.st.expv = 1'b0;
      end
      w = kvtok_done(w);
    end
    return w;
  endfunction

  // Whole effect of one input beat: next state plus its burst of events
  function automatic kvtok_work_t kvtok_process(kvtok_state_t st, logic [7:0] b,
                                                logic present, logic last,
                                                logic [5:0] max_depth);
    kvtok_work_t w;
    logic [7:0]  want;
    w.st    = st;
    w.burst = '0;
    w.again = 1'b0;
    if (!st.fin) begin
      if (present) begin
        if (w.st.bom != BOM_DONE) begin
          want = (w.st.bom == 2'd0) ? CH_BOM0 : ((w.st.bom == 2'd1) ? CH_BOM1 : CH_BOM2);
          if (b == want) begin
            w.st.bom = w.st.bom + 2'd1;
          end else begin
            w = kvtok_replay(w, max_depth);
            w = kvtok_lex(w, b, max_depth);
          end
        end else begin
          w = kvtok_lex(w, b, max_depth);
        end
      end
      if (last && !w.st.fin) w = kvtok_finish_text(w, max_depth);
    end
    return w;
  endfunction

endpackage

// File: rtl/core/kvtok_burst_queue.sv
// kvtok_burst_queue: two-slot queue of event bursts; the head slot drains one event per beat while out_stall is low.
// Depends on kvtok_pkg (burst and event types).
`timescale 1ns / 1ps

module kvtok_burst_queue
  import kvtok_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  kvtok_burst_t           push_burst,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output kvtok_event_t           out_event,
  output logic                   out_last
);

  logic                   a_valid_r, a_valid_nxt;
  logic                   b_valid_r, b_valid_nxt;
  kvtok_burst_t           a_r, a_nxt;
  kvtok_burst_t           b_r, b_nxt;
  logic [KVTOK_IDX_W-1:0] a_idx_r, a_idx_nxt;
  logic [KVTOK_IDX_W-1:0] last_idx;
  logic                   take;
  logic                   pop_last;
  logic                   a_free;

  assign last_idx  = KVTOK_IDX_W'(a_r.cnt - KVTOK_CNT_W'(1));
  assign out_valid = a_valid_r;
  assign out_event = a_r.ev[a_idx_r];
  assign out_last  = (a_idx_r == last_idx);
  assign full      = b_valid_r;
  assign take      = a_valid_r && !out_stall;
  assign pop_last  = take && out_last;
  assign a_free    = !a_valid_r || pop_last;

  always_comb begin
    a_valid_nxt = a_valid_r;
    b_valid_nxt = b_valid_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    a_idx_nxt   = a_idx_r;
    if (take && !pop_last) a_idx_nxt = a_idx_r + KVTOK_IDX_W'(1);
    if (a_free) begin
      a_idx_nxt = '0;
      if (b_valid_r) begin
        a_nxt       = b_r;
        a_valid_nxt = 1'b1;
        b_nxt       = push_burst;
        b_valid_nxt = push;
      end else begin
        a_nxt       = push_burst;
        a_valid_nxt = push;
      end
    end else if (push) begin
      b_nxt       = push_burst;
      b_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      a_idx_r   <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      a_idx_r   <= a_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

`ifndef SYNTHESIS
  a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> a_valid_r)
    else $error("tail slot filled while head slot empty");

  a_head_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> (a_r.cnt != '0 && a_r.cnt <= KVTOK_CNT_W'(KVTOK_MAX_EVENTS)))
    else $error("head burst holds no events or too many");

  a_stall_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event) && $stable(out_last)))
    else $error("stalled event changed");
`endif

endmodule

// File: rtl/core/keyvalue_text_tokenizer_unit.sv
// keyvalue_text_tokenizer_unit: streaming tokenizer for brace-structured key/value text.
// Path: an accepted beat waits in the input register, is lexed combinationally, and its
//   burst is registered into the burst queue, whose head slot drives the output.
// Throughput: one input beat per cycle while the burst queue is not full; a beat's events
//   leave one per cycle while out_stall is low (single output port), at most 8 per beat.
// Reset: synchronous, active low; clears lexer state, byte-order-mark check and all valids.
`timescale 1ns / 1ps

module keyvalue_text_tokenizer_unit
  import kvtok_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = KVTOK_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_byte_present,
  input  logic       in_text_end,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_kind,
  output logic [7:0] out_event_byte,
  output logic [5:0] out_nest_depth,
  output logic       out_parse_success,
  output logic       out_depth_overflow,
  output logic       out_last_of_run
);

  localparam logic [5:0] MaxDepth6 = 6'(MAX_DEPTH);

  // Input register: one beat waiting for the lexer
  logic         s0_valid_r, s0_valid_nxt;
  logic [7:0]   s0_byte_r;
  logic         s0_present_r;
  logic         s0_end_r;

  // Lexer / parser state, updated once per beat
  kvtok_state_t st_r, st_nxt;

  kvtok_work_t  gen;
  logic         q_full;
  logic         advance;
  logic         push;
  logic         in_take;
  kvtok_event_t q_event;

  // The input register moves on whenever the burst queue has a free slot;
  // in_stall comes straight from registers, so no path from out_stall.
  assign in_stall = s0_valid_r && q_full;
  assign in_take  = in_valid && !in_stall;
  assign advance  = s0_valid_r && !q_full;

  // All lexing for one byte (mark replay, up to three lexer passes per byte, end of text)
  // is shallow compare/select logic on the state register.
  assign gen    = kvtok_process(st_r, s0_byte_r, s0_present_r, s0_end_r, MaxDepth6);
  assign push   = advance && (gen.burst.cnt != '0);
  assign st_nxt = advance ? gen.st : st_r;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_take) s0_valid_nxt = 1'b1;
    else if (advance) s0_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      st_r       <= KVTOK_STATE_RESET;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      st_r       <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_byte_r    <= in_byte;
      s0_present_r <= in_byte_present;
      s0_end_r     <= in_text_end;
    end
  end

  // Bursts wait here and leave one event per beat while out_stall is low
  kvtok_burst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_burst (gen.burst),
    .full       (q_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_event  (q_event),
    .out_last   (out_last_of_run)
  );

  assign out_event_kind     = 3'(q_event.kind);
  assign out_event_byte     = q_event.data;
  assign out_nest_depth     = q_event.depth;
  assign out_parse_success  = q_event.succ;
  assign out_depth_overflow = q_event.ovf;

`ifndef SYNTHESIS
  a_stall_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with nothing on the output");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nest_depth <= MaxDepth6))
    else $error("reported depth beyond the bound");

  a_silent_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fin |-> !push)
    else $error("events produced after the parse finished");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == 3'(KIND_DONE)) |-> out_last_of_run)
    else $error("done event not last of its beat");
`endif

endmodule

// File: sim/kvtok_event_checker.sv
// kvtok_event_checker: watches both channels of keyvalue_text_tokenizer_unit, predicts the
// event stream of every accepted input beat and compares it with the result beats.
// Depends on kvtok_pkg for the event kinds, lexer modes and character constants.
`timescale 1ns / 1ps

module kvtok_event_checker
  import kvtok_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = KVTOK_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_byte_present,
  input  logic       in_text_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_event_kind,
  input  logic [7:0] out_event_byte,
  input  logic [5:0] out_nest_depth,
  input  logic       out_parse_success,
  input  logic       out_depth_overflow,
  input  logic       out_last_of_run,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    kvtok_kind_t kind;
    logic [7:0]  data;
    logic [5:0]  depth;
    logic        succ;
    logic        ovf;
    logic        last;
  } tok_event_t;

  // tokenizer state as this checker sees it
  logic [1:0]  mark_seen;
  logic [7:0]  mark_held [2];
  kvtok_mode_t scan_mode;
  logic        want_value;
  logic [5:0]  depth;
  logic        top_seen;
  logic        ended;
  logic        overflowed;

  tok_event_t  beat_events[$];
  tok_event_t  expected_events[$];

  function automatic void add_event(kvtok_kind_t kind, logic [7:0] data, logic succ,
                                    logic ovf);
    tok_event_t ev;
    if (beat_events.size() < KVTOK_MAX_EVENTS) begin
      ev.kind  = kind;
      ev.data  = data;
      ev.depth = depth;
      ev.succ  = succ;
      ev.ovf   = ovf;
      ev.last  = 1'b0;
      beat_events = {beat_events, ev};
    end
  endfunction

  function automatic void emit_done();
    add_event(KIND_DONE, 8'h00, top_seen, overflowed);
    ended = 1'b1;
  endfunction

  function automatic void token_byte(logic [7:0] b);
    add_event(want_value ? KIND_VAL_BYTE : KIND_KEY_BYTE, b, 1'b0, 1'b0);
  endfunction

  function automatic void token_end();
    if (want_value) begin
      add_event(KIND_VAL_END, 8'h00, 1'b0, 1'b0);
      want_value = 1'b0;
    end else begin
      add_event(KIND_KEY_END, 8'h00, 1'b0, 1'b0);
      if (depth == 6'd0) top_seen = 1'b1;
      want_value = 1'b1;
    end
  endfunction

  function automatic void open_block();
    if (want_value) begin
      want_value = 1'b0;
      if (depth >= MAX_DEPTH) overflowed = 1'b1;
      else depth = depth + 6'd1;
      add_event(KIND_OPEN, 8'h00, 1'b0, 1'b0);
    end
  endfunction

  function automatic void close_block();
    if (want_value) begin
      add_event(KIND_NO_VALUE, 8'h00, 1'b0, 1'b0);
      want_value = 1'b0;
    end
    if (depth == 6'd0) begin
      emit_done();
    end else begin
      depth = depth - 6'd1;
      add_event(KIND_CLOSE, 8'h00, 1'b0, 1'b0);
    end
  endfunction

  // a byte that ends a lone slash or a bareword is looked at again from the new mode
  function automatic void scan_byte(logic [7:0] b);
    logic redo;
    redo = 1'b1;
    while (redo && !ended) begin
      redo = 1'b0;
      case (scan_mode)
        MODE_GAP: begin
          if (b > CH_SPACE) begin
            if (b == CH_SLASH) scan_mode = MODE_SLASH;
            else if (b == CH_LBRACE) open_block();
            else if (b == CH_RBRACE) close_block();
            else if (b == CH_QUOTE) scan_mode = MODE_QUOTE;
            else begin
              token_byte(b);
              scan_mode = MODE_BARE;
            end
          end
        end
        MODE_SLASH: begin
          if (b == CH_SLASH) scan_mode = MODE_LINE;
          else if (b == CH_STAR) scan_mode = MODE_BLK;
          else begin
            token_byte(CH_SLASH);
            scan_mode = MODE_BARE;
            redo = 1'b1;
          end
        end
        MODE_LINE: begin
          if (b == CH_NL) scan_mode = MODE_GAP;
        end
        MODE_BLK: begin
          if (b == CH_STAR) scan_mode = MODE_BLKSTAR;
        end
        MODE_BLKSTAR: begin
          if (b == CH_SLASH) scan_mode = MODE_GAP;
          else if (b != CH_STAR) scan_mode = MODE_BLK;
        end
        MODE_QUOTE: begin
          if (b == CH_QUOTE) begin
            token_end();
            scan_mode = MODE_GAP;
          end else if (b == CH_BSLASH) begin
            scan_mode = MODE_ESC;
          end else begin
            token_byte(b);
          end
        end
        MODE_ESC: begin
          case (b)
            CH_LOW_N: token_byte(CH_NL);
            CH_LOW_T: token_byte(CH_TAB);
            default:  token_byte(b);
          endcase
          scan_mode = MODE_QUOTE;
        end
        default: begin
          if (b <= CH_SPACE || b == CH_LBRACE || b == CH_RBRACE || b == CH_QUOTE) begin
            token_end();
            scan_mode = MODE_GAP;
            redo = 1'b1;
          end else begin
            token_byte(b);
          end
        end
      endcase
    end
  endfunction

  function automatic void replay_mark();
    logic [1:0] n;
    n = mark_seen;
    mark_seen = BOM_DONE;
    if (n >= 2'd1) scan_byte(mark_held[0]);
    if (n >= 2'd2) scan_byte(mark_held[1]);
  endfunction

  function automatic void end_of_text();
    if (mark_seen != BOM_DONE) replay_mark();
    if (!ended) begin
      case (scan_mode)
        MODE_SLASH: begin
          token_byte(CH_SLASH);
          token_end();
        end
        MODE_ESC: begin
          token_byte(CH_BSLASH);
          token_end();
        end
        MODE_QUOTE, MODE_BARE: token_end();
        default: begin
        end
      endcase
      scan_mode = MODE_GAP;
      if (want_value) begin
        add_event(KIND_NO_VALUE, 8'h00, 1'b0, 1'b0);
        want_value = 1'b0;
      end
      emit_done();
    end
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic present, logic fin);
    logic [7:0] mark_byte;
    beat_events.delete();
    if (!ended) begin
      if (present) begin
        if (mark_seen != BOM_DONE) begin
          case (mark_seen)
            2'd0:    mark_byte = CH_BOM0;
            2'd1:    mark_byte = CH_BOM1;
            default: mark_byte = CH_BOM2;
          endcase
          if (b == mark_byte) begin
            if (mark_seen == 2'd2) mark_seen = BOM_DONE;
            else begin
              mark_held[mark_seen[0]] = b;
              mark_seen = mark_seen + 2'd1;
            end
          end else begin
            replay_mark();
            scan_byte(b);
          end
        end else begin
          scan_byte(b);
        end
      end
      if (fin && !ended) end_of_text();
    end
    if (beat_events.size() > 0) beat_events[beat_events.size() - 1].last = 1'b1;
    expected_events = {expected_events, beat_events};
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tok_event_t head;
    if (!rst_n) begin
      mark_seen  = 2'd0;
      mark_held[0] = 8'h00;
      mark_held[1] = 8'h00;
      scan_mode  = MODE_GAP;
      want_value = 1'b0;
      depth      = 6'd0;
      top_seen   = 1'b0;
      ended      = 1'b0;
      overflowed = 1'b0;
      expected_events.delete();
      errors     = 0;
      pending    = 0;
    end else begin
      if (in_valid && !in_stall) predict_beat(in_byte, in_byte_present, in_text_end);
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected event, expected none, actual kind %0d byte %0d",
                   $time, out_event_kind, out_event_byte);
        end else begin
          head = expected_events.pop_front();
          check_field("event_kind", 8'(head.kind), 8'(out_event_kind));
          check_field("event_byte", head.data, out_event_byte);
          check_field("nest_depth", 8'(head.depth), 8'(out_nest_depth));
          check_field("parse_success", 8'(head.succ), 8'(out_parse_success));
          check_field("depth_overflow", 8'(head.ovf), 8'(out_depth_overflow));
          check_field("last_of_run", 8'(head.last), 8'(out_last_of_run));
        end
      end
      pending = expected_events.size();
    end
  end

endmodule

// File: sim/keyvalue_text_tokenizer_unit_tb.sv
// keyvalue_text_tokenizer_unit_tb: feeds one long key/value text through the tokenizer
// and gives the verdict; prediction and comparison live in kvtok_event_checker.
// Depends on kvtok_pkg, keyvalue_text_tokenizer_unit and kvtok_event_checker.
`timescale 1ns / 1ps

module keyvalue_text_tokenizer_unit_tb;
  import kvtok_pkg::*;

  localparam int unsigned DEPTH_LIMIT = KVTOK_MAX_DEPTH;
  // beats that carry a byte or the end marker, directed part included
  localparam int TOTAL_BEATS = 470;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_byte_present;
  logic       in_text_end;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_event_kind;
  logic [7:0] out_event_byte;
  logic [5:0] out_nest_depth;
  logic       out_parse_success;
  logic       out_depth_overflow;
  logic       out_last_of_run;

  int errors;
  int pending;

  // stimulus bookkeeping: the generator mirrors nesting and key/value role so that it
  // never closes the top level by accident before the chosen ending
  int beats_sent;
  int nest;
  bit at_value;
  bit jitter;     // random idling on both sides in this stretch
  bit quiet;      // closing part of the run: no idling at all
  bit long_hold;  // asks the receiver for one long hold-off

  keyvalue_text_tokenizer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_byte_present    (in_byte_present),
    .in_text_end        (in_text_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_event_byte     (out_event_byte),
    .out_nest_depth     (out_nest_depth),
    .out_parse_success  (out_parse_success),
    .out_depth_overflow (out_depth_overflow),
    .out_last_of_run    (out_last_of_run)
  );

  kvtok_event_checker #(.MAX_DEPTH(DEPTH_LIMIT)) event_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_byte_present    (in_byte_present),
    .in_text_end        (in_text_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_event_byte     (out_event_byte),
    .out_nest_depth     (out_nest_depth),
    .out_parse_success  (out_parse_success),
    .out_depth_overflow (out_depth_overflow),
    .out_last_of_run    (out_last_of_run),
    .errors             (errors),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("keyvalue_text_tokenizer_unit verification failed");
    $finish;
  end

  // Receiver: short random stall bursts while jitter is on, one long hold-off on request
  // so the block backs up into its input, nothing once the run gets quiet.
  initial begin
    int span;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (120) @(negedge clk);
        out_stall = 1'b0;
        long_hold = 1'b0;
      end else if (jitter && !quiet && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 7);
        out_stall = 1'b1;
        repeat (span) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // One input beat: maybe an idle burst first, then hold the payload until accepted.
  // Payload changes only at the falling edge; acceptance is read at the rising edge.
  task automatic send_beat(input logic [7:0] b, input bit present = 1'b1,
                           input bit fin = 1'b0);
    int gap;
    if (jitter && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_byte         = b;
    in_byte_present = present;
    in_text_end     = fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (present || fin) beats_sent++;
  endtask

  task automatic send_text(input string s, input bit fin_last = 1'b0);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b1, fin_last && (i == s.len() - 1));
  endtask

  // bareword byte; a leading one must not look like a comment opener
  function automatic logic [7:0] bare_char(bit lead);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c <= CH_SPACE || c == CH_LBRACE || c == CH_RBRACE || c == CH_QUOTE ||
           (lead && (c == CH_SLASH || c == CH_STAR)));
    return c;
  endfunction

  // whitespace is every byte up to and including space
  task automatic send_gap();
    repeat ($urandom_range(1, 2)) send_beat(8'($urandom_range(0, 32)));
  endtask

  task automatic send_bare();
    int n;
    n = $urandom_range(1, 6);
    if ($urandom_range(0, 7) == 0) send_beat(CH_SLASH);  // lone slash opens a word
    for (int i = 0; i < n; i++) send_beat(bare_char(i == 0));
    send_gap();
  endtask

  task automatic send_quoted();
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 8);
    send_beat(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_QUOTE || c == CH_BSLASH) begin
        send_beat(CH_BSLASH);
        send_beat(c);
      end else if ($urandom_range(0, 7) == 0) begin
        send_beat(CH_BSLASH);
        case ($urandom_range(0, 2))
          0:       send_beat(CH_LOW_N);
          1:       send_beat(CH_LOW_T);
          default: send_beat(c);
        endcase
      end else begin
        send_beat(c);
      end
    end
    send_beat(CH_QUOTE);
    if ($urandom_range(0, 1)) send_gap();
  endtask

  task automatic send_comment();
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 5);
    send_beat(CH_SLASH);
    if ($urandom_range(0, 1)) begin
      send_beat(CH_SLASH);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
        send_beat(c);
      end
      send_beat(CH_NL);
    end else begin
      send_beat(CH_STAR);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_SLASH);
        send_beat(c);
      end
      send_beat(CH_STAR);
      send_beat(CH_SLASH);
    end
  endtask

  task automatic send_token();
    if ($urandom_range(0, 1)) send_quoted();
    else send_bare();
  endtask

  initial begin
    int pick;
    int close_w;
    int next_toggle;
    bit hold_done;
    bit pause_done;
    bit dive_done;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_byte         = 8'h00;
    in_byte_present = 1'b0;
    in_text_end     = 1'b0;
    beats_sent      = 0;
    nest            = 0;
    at_value        = 1'b0;
    jitter          = 1'b1;
    quiet           = 1'b0;
    long_hold       = 1'b0;
    hold_done       = 1'b0;
    pause_done      = 1'b0;
    dive_done       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Byte-order mark at the head of the text: whole, two bytes then a mismatch, one
    // byte then a mismatch, or absent. Partial marks come back out as a bareword key.
    case ($urandom_range(0, 3))
      0: begin
        send_beat(CH_BOM0);
        send_beat(CH_BOM1);
        send_beat(CH_BOM2);
      end
      1: begin
        send_beat(CH_BOM0);
        send_beat(CH_BOM1);
        send_beat(CH_SPACE);
        send_text("v ");
      end
      2: begin
        send_beat(CH_BOM0);
        send_beat(8'h41);
        send_beat(CH_SPACE);
        send_text("v ");
      end
      default: begin
      end
    endcase

    // Directed: quoted key with newline, tab, quote and plain escapes plus the byte
    // extremes, a value opened by a lone slash, both comment styles (star run before the
    // closing slash), a stray open brace in key position, a bareword cut short by an
    // open brace, a key closed off by a brace, and a beat with no byte.
    send_beat(CH_QUOTE);
    send_text("k\\n\\t\\\"\\q");
    send_beat(8'hFF);
    send_beat(8'h00);
    send_beat(CH_QUOTE);
    send_text("/x ");
    send_text("//\n/***/");
    send_beat(CH_LBRACE);
    send_text("b{k}");
    send_beat(8'h00, 1'b0);
    next_toggle = beats_sent + 50;

    // Random part: well-formed key/value text with random content, braces and comments
    // mixed in, plus a few beats with no byte and stray opens.
    while (beats_sent < TOTAL_BEATS) begin
      if (beats_sent >= next_toggle) begin
        jitter = $urandom_range(0, 2) != 0;
        next_toggle += 50;
      end
      quiet = beats_sent >= TOTAL_BEATS - 40;
      if (!hold_done && beats_sent >= 120) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && beats_sent >= 300) begin
        // let the block drain completely before carrying on
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        pause_done = 1'b1;
      end
      if (!dive_done && beats_sent >= 200 && !at_value) begin
        // nest past the depth bound so the depth saturates and overflow is flagged
        repeat (DEPTH_LIMIT + 3) begin
          send_text("d{");
          if (nest < DEPTH_LIMIT) nest++;
        end
        dive_done = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (!at_value) begin
        close_w = (nest > 8) ? 50 : 4 * nest;
        if (pick < 8) send_comment();
        else if (pick < 11) send_beat(CH_LBRACE);
        else if (pick < 13) send_beat(8'($urandom_range(0, 255)), 1'b0);
        else if (nest > 0 && pick < 13 + close_w) begin
          send_beat(CH_RBRACE);
          nest--;
        end else begin
          send_token();
          at_value = 1'b1;
        end
      end else begin
        if (pick < 6) send_comment();
        else if (nest > 0 && pick < 10) begin
          // key left without a value, then its block closes
          send_beat(CH_RBRACE);
          nest--;
          at_value = 1'b0;
        end else if (pick < 30) begin
          send_beat(CH_LBRACE);
          if (nest < DEPTH_LIMIT) nest++;
          at_value = 1'b0;
        end else begin
          send_token();
          at_value = 1'b0;
        end
      end
    end

    // Ending: close back to the top level and past it, or end the text in the middle
    // of a slash, an escape, a quote, a bareword, a block comment, or on a bare marker.
    quiet = 1'b1;
    case ($urandom_range(0, 6))
      0: begin
        while (nest > 0) begin
          send_beat(CH_RBRACE);
          nest--;
        end
        send_beat(CH_RBRACE, 1'b1, 1'($urandom_range(0, 1)));
      end
      1:       send_beat(CH_SLASH, 1'b1, 1'b1);
      2:       send_text("\"a\\", 1'b1);
      3:       send_text("\"ab", 1'b1);
      4:       send_text("xy", 1'b1);
      5:       send_beat(8'h00, 1'b0, 1'b1);
      default: send_text("/*z", 1'b1);
    endcase

    // the parse is over: these must be swallowed without events
    repeat (4) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("keyvalue_text_tokenizer_unit verification clean");
    end else begin
      $display("keyvalue_text_tokenizer_unit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/kvtok_pkg.sv
rtl/core/kvtok_burst_queue.sv
rtl/core/keyvalue_text_tokenizer_unit.sv
sim/kvtok_event_checker.sv
sim/keyvalue_text_tokenizer_unit_tb.sv
